@@ hdl/asft_pkg.sv @@
// Shared types and constants of the asynchronous serial frame transmitter.
package asft_pkg;

  // Field widths
  localparam int unsigned TX_BYTE_W    = 8;
  localparam int unsigned BIT_KIND_W   = 2;
  localparam int unsigned CFG_INDEX_W  = 8;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned DATA_BITS_W  = 4;
  localparam int unsigned PARITY_W     = 2;
  localparam int unsigned STOP_BITS_W  = 2;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned DATA_IDX_W   = 3;

  // Register reset values
  localparam logic [DATA_BITS_W-1:0] DATA_BITS_RST  = 4'd8;
  localparam logic [PARITY_W-1:0]    PARITY_RST     = 2'd0;
  localparam logic [STOP_BITS_W-1:0] STOP_BITS_RST  = 2'd1;
  localparam logic [PERIOD_W-1:0]    BIT_PERIOD_RST = 16'd2187;

  // Depth of the frame queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DATA_BITS  = 8'd0,
    REG_PARITY     = 8'd1,
    REG_STOP_BITS  = 8'd2,
    REG_BIT_PERIOD = 8'd3
  } cfg_reg_e;

  // Parity mode codes
  typedef enum logic [PARITY_W-1:0] {
    PAR_NONE = 2'd0,
    PAR_EVEN = 2'd1,
    PAR_ODD  = 2'd2,
    PAR_RSVD = 2'd3
  } parity_e;

  // Kind of line level in a frame
  typedef enum logic [BIT_KIND_W-1:0] {
    KIND_START  = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_PARITY = 2'd2,
    KIND_STOP   = 2'd3
  } bit_kind_e;

  // Frame descriptor handed from the front to the back
  typedef struct packed {
    logic [TX_BYTE_W-1:0]  data;
    logic [DATA_IDX_W-1:0] last_data;  // index of the final data bit
    logic                  par_en;
    logic                  par_odd;
    logic                  two_stop;
  } frame_t;

endpackage

@@ hdl/asft_intf.sv @@
// Handshake channels of the transmitter: byte input, line output, register writes.
interface asft_byte_if import asft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TX_BYTE_W-1:0] tx_byte;

  modport source (output valid, output tx_byte, input ready);
  modport sink (input valid, input tx_byte, output ready);
endinterface

interface asft_line_if import asft_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  line_level;
  logic [BIT_KIND_W-1:0] bit_kind;
  logic                  frame_end;

  modport source (output valid, output line_level, output bit_kind, output frame_end,
                  input ready);
  modport sink (input valid, input line_level, input bit_kind, input frame_end,
                output ready);
endinterface

interface asft_cfg_if import asft_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/asft_front.sv @@
// Front end: register file, byte intake and frame classification.
module asft_front import asft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  asft_byte_if.sink           tx_in,
  asft_cfg_if.sink            cfg_wr,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output frame_t              push_frame_o,
  output logic [PERIOD_W-1:0] bit_period_o
);

  logic [DATA_BITS_W-1:0] data_bits_q;
  logic [PARITY_W-1:0]    parity_q;
  logic [STOP_BITS_W-1:0] stop_bits_q;
  logic [PERIOD_W-1:0]    bit_period_q;
  logic [DATA_IDX_W-1:0]  last_data;

  // Register writes are always taken
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q  <= DATA_BITS_RST;
      parity_q     <= PARITY_RST;
      stop_bits_q  <= STOP_BITS_RST;
      bit_period_q <= BIT_PERIOD_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_DATA_BITS:  data_bits_q  <= cfg_wr.data[DATA_BITS_W-1:0];
        REG_PARITY:     parity_q     <= cfg_wr.data[PARITY_W-1:0];
        REG_STOP_BITS:  stop_bits_q  <= cfg_wr.data[STOP_BITS_W-1:0];
        REG_BIT_PERIOD: bit_period_q <= cfg_wr.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the data width to five..eight bits, as the index of the last bit
  always_comb begin
    if (data_bits_q < 4'd5) begin
      last_data = 3'd4;
    end else if (data_bits_q >= 4'd8) begin
      last_data = 3'd7;
    end else begin
      last_data = data_bits_q[DATA_IDX_W-1:0] - 3'd1;
    end
  end

  // Classify the byte into a frame descriptor and pass it on
  always_comb begin
    push_frame_o.data      = tx_in.tx_byte;
    push_frame_o.last_data = last_data;
    push_frame_o.par_en    = (parity_q == PAR_EVEN) || (parity_q == PAR_ODD);
    push_frame_o.par_odd   = (parity_q == PAR_ODD);
    push_frame_o.two_stop  = stop_bits_q[1];
  end

  assign push_valid_o = tx_in.valid;
  assign tx_in.ready  = push_ready_i;
  assign bit_period_o = bit_period_q;

endmodule

@@ hdl/asft_queue.sv @@
// Short frame queue between the front and back ends.
module asft_queue import asft_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  frame_t push_frame_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output frame_t pop_frame_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_frame_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming descriptor
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count did not grow on a lone push");
`endif

endmodule

@@ hdl/asft_back.sv @@
// Back end: bit-period timer and frame serialiser driving the line channel.
module asft_back import asft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  frame_t              pop_frame_i,
  input  logic [PERIOD_W-1:0] bit_period_i,
  asft_line_if.source         tx_out
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_PARITY,
    ST_STOP
  } state_e;

  state_e                state_q, state_d;
  frame_t                desc_q, desc_d;
  logic [TX_BYTE_W-1:0]  shift_q, shift_d;
  logic [DATA_IDX_W-1:0] cnt_q, cnt_d;
  logic                  par_q, par_d;
  logic [PERIOD_W-1:0]   timer_q, timer_d;
  logic                  out_valid_q, out_valid_d;
  logic                  level_q, level_d;
  bit_kind_e             kind_q, kind_d;
  logic                  end_q, end_d;

  logic [PERIOD_W-1:0]   period_m1;
  logic                  timer_done;
  logic                  out_free;
  logic                  advance;
  logic                  emit;

  // A zero bit_period is treated the same as a bit_period of 1
  assign period_m1  = (bit_period_i == '0) ? '0 : bit_period_i - 1'b1;
  assign timer_done = (timer_q == period_m1);
  assign out_free   = !out_valid_q || tx_out.ready;
  assign advance    = timer_done && out_free;
  assign pop_ready_o = (state_q == ST_IDLE) && out_free;

  always_comb begin
    state_d     = state_q;
    desc_d      = desc_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    par_d       = par_q;
    level_d     = level_q;
    kind_d      = kind_q;
    end_d       = end_q;
    emit        = 1'b0;
    out_valid_d = out_valid_q && !tx_out.ready;
    timer_d     = timer_done ? timer_q : timer_q + 1'b1;

    case (state_q)
      ST_IDLE: begin
        // Take the next frame and show its start bit
        if (pop_valid_i && out_free) begin
          desc_d  = pop_frame_i;
          shift_d = pop_frame_i.data;
          par_d   = 1'b0;
          emit    = 1'b1;
          level_d = 1'b0;
          kind_d  = KIND_START;
          end_d   = 1'b0;
          state_d = ST_START;
        end
      end
      ST_START: begin
        // First data bit, least significant first
        if (advance) begin
          emit    = 1'b1;
          level_d = shift_q[0];
          kind_d  = KIND_DATA;
          end_d   = 1'b0;
          par_d   = shift_q[0];
          shift_d = shift_q >> 1;
          cnt_d   = '0;
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        if (advance) begin
          emit = 1'b1;
          if (cnt_q == desc_q.last_data) begin
            if (desc_q.par_en) begin
              level_d = par_q ^ desc_q.par_odd;
              kind_d  = KIND_PARITY;
              end_d   = 1'b0;
              state_d = ST_PARITY;
            end else begin
              level_d = 1'b1;
              kind_d  = KIND_STOP;
              end_d   = !desc_q.two_stop;
              state_d = ST_STOP;
            end
          end else begin
            level_d = shift_q[0];
            kind_d  = KIND_DATA;
            end_d   = 1'b0;
            par_d   = par_q ^ shift_q[0];
            shift_d = shift_q >> 1;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end
      ST_PARITY: begin
        if (advance) begin
          emit    = 1'b1;
          level_d = 1'b1;
          kind_d  = KIND_STOP;
          end_d   = !desc_q.two_stop;
          state_d = ST_STOP;
        end
      end
      ST_STOP: begin
        // Show a second stop bit if one is due, else drop back to idle once the final stop period has run out
        if (advance) begin
          if (end_q) begin
            state_d = ST_IDLE;
          end else begin
            emit    = 1'b1;
            level_d = 1'b1;
            kind_d  = KIND_STOP;
            end_d   = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      timer_d     = '0;
    end
  end

  // Hold state and the registered line beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      timer_q     <= '0;
      cnt_q       <= '0;
      par_q       <= 1'b0;
      desc_q      <= '0;
      shift_q     <= '0;
      level_q     <= 1'b1;
      kind_q      <= KIND_STOP;
      end_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      timer_q     <= timer_d;
      cnt_q       <= cnt_d;
      par_q       <= par_d;
      desc_q      <= desc_d;
      shift_q     <= shift_d;
      level_q     <= level_d;
      kind_q      <= kind_d;
      end_q       <= end_d;
    end
  end

  assign tx_out.valid      = out_valid_q;
  assign tx_out.line_level = level_q;
  assign tx_out.bit_kind   = kind_q;
  assign tx_out.frame_end  = end_q;

`ifndef SYNTHESIS
  a_emit_after_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (state_q != ST_IDLE)) |-> timer_done)
    else $error("line level changed before its bit period ran out");

  a_data_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> (cnt_q <= desc_q.last_data))
    else $error("data bit count ran past the frame width");
`endif

endmodule

@@ hdl/async_serial_frame_transmitter_top.sv @@
// With the serialiser idle, the start bit is offered once its byte has passed the queue and the line register.
// Frames are 7 to 12 bits long; the back end's bit-period timer sets the frame rate,
// and the queue lets bytes wait.
// A line beat not taken in time stretches its bit period until it is taken.
// Reset (async, active low) clears the queue and serialiser and loads register defaults.
module async_serial_frame_transmitter_top import asft_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  asft_byte_if.sink   tx_in,
  asft_line_if.source tx_out,
  asft_cfg_if.sink    cfg_wr
);

  logic                push_valid, push_ready;
  frame_t              push_frame;
  logic                pop_valid, pop_ready;
  frame_t              pop_frame;
  logic [PERIOD_W-1:0] bit_period;

  // Intake and classification
  asft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tx_in        (tx_in),
    .cfg_wr       (cfg_wr),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_frame_o (push_frame),
    .bit_period_o (bit_period)
  );

  // Frame queue
  asft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_frame_i (push_frame),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_frame_o  (pop_frame)
  );

  // Serialiser
  asft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_frame_i  (pop_frame),
    .bit_period_i (bit_period),
    .tx_out       (tx_out)
  );

endmodule
